[design/lz77_pkg.sv]
// Package: shared types for the LZ77 triplet compressor.
package lz77_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] match_offset;
        logic [7:0] match_length;
        logic [7:0] literal_byte;
        logic       final_triplet;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic step;     // evaluate the held byte and update the window
        logic clear;    // return window and match state to reset
    } lz77_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       emit;
        out_item_t  item;
    } lz77_stat_t;

endpackage

[design/lz77_stream_if.sv]
// Interface: valid/ready channel carrying one payload item.
interface lz77_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/lz77_datapath.sv]
// Datapath: history shift line, per-offset candidate cells, run counter.
module lz77_datapath #(
    parameter int WINDOW_SIZE = 255,
    parameter int MAX_MATCH   = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lz77_pkg::lz77_cmd_t cmd,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output lz77_pkg::lz77_stat_t stat
);
    localparam int FW = $clog2(WINDOW_SIZE + 1);

    logic [7:0]             hist_reg [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] alive_reg, alive_next;
    logic [7:0]             run_reg, run_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic                   matching_reg, matching_next;

    logic [WINDOW_SIZE-1:0] base, surv;
    logic                   any;
    logic [7:0]             best_base, best_surv;

    // Cells: one comparator per offset.
    always_comb
    begin
        for (int d = 0; d < WINDOW_SIZE; d++)
        begin
            base[d] = matching_reg ? alive_reg[d] : (FW'(d) < fill_reg);
            surv[d] = base[d] && (hist_reg[d] == in_byte) && (run_reg < 8'(MAX_MATCH));
        end
        any = |surv;
    end

    // Largest live offset; priority encode from the top.
    always_comb
    begin
        best_base = '0;
        best_surv = '0;
        for (int d = 0; d < WINDOW_SIZE; d++)
        begin
            if (base[d]) best_base = 8'(d + 1);
            if (surv[d]) best_surv = 8'(d + 1);
        end
    end

    always_comb
    begin
        stat = '0;
        alive_next    = alive_reg;
        run_next      = run_reg;
        matching_next = matching_reg;
        fill_next     = fill_reg;
        if (cmd.step)
        begin
            fill_next = (fill_reg < FW'(WINDOW_SIZE)) ? fill_reg + 1'b1 : fill_reg;
            if (any)
            begin
                run_next      = run_reg + 8'd1;
                matching_next = 1'b1;
                alive_next    = surv;
                stat.emit     = in_last;
                stat.item     = '{best_surv, run_reg + 8'd1, 8'd0, 1'b1};
            end
            else
            begin
                stat.emit     = 1'b1;
                stat.item     = '{(run_reg == 8'd0) ? 8'd0 : best_base, run_reg,
                                  in_byte, in_last};
                run_next      = '0;
                matching_next = 1'b0;
                alive_next    = '0;
            end
        end
        if (cmd.clear)
        begin
            alive_next    = '0;
            run_next      = '0;
            matching_next = 1'b0;
            fill_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg    <= '0;
            run_reg      <= '0;
            fill_reg     <= '0;
            matching_reg <= 1'b0;
        end
        else
        begin
            alive_reg    <= alive_next;
            run_reg      <= run_next;
            fill_reg     <= fill_next;
            matching_reg <= matching_next;
        end
    end

    // History shift line; entries beyond the fill are never used.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            hist_reg[0] <= in_byte;
            for (int d = 1; d < WINDOW_SIZE; d++)
                hist_reg[d] <= hist_reg[d-1];
        end
    end

    a_run_cap: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= 8'(MAX_MATCH)) else $error("run length beyond cap");
    a_match_alive: assert property (@(posedge clk) disable iff (!rst_n)
        matching_reg |-> (alive_reg != '0)) else $error("matching with no candidate");
    a_idle_run: assert property (@(posedge clk) disable iff (!rst_n)
        !matching_reg |-> run_reg == 8'd0) else $error("run without match");
endmodule

[design/lz77_ctrl.sv]
// Controller: input take, output register and end-of-stream clear.
module lz77_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lz77_pkg::out_item_t  out_item,
    output lz77_pkg::lz77_cmd_t  cmd,
    input  lz77_pkg::lz77_stat_t stat
);
    typedef enum logic {ST_RUN, ST_HOLD} state_t;
    state_t state_reg;
    lz77_pkg::out_item_t item_reg;

    // Take a byte when the output slot is free or being emptied.
    assign in_ready  = (state_reg == ST_RUN) || out_ready;
    assign cmd.step  = in_valid && in_ready;
    assign cmd.clear = cmd.step && in_last;
    assign out_valid = (state_reg == ST_HOLD);
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            item_reg  <= '0;
        end
        else
        begin
            if (cmd.step && stat.emit)
                item_reg <= stat.item;
            unique case (state_reg)
                ST_RUN:
                    if (cmd.step && stat.emit) state_reg <= ST_HOLD;
                ST_HOLD:
                    if (out_ready && !(cmd.step && stat.emit)) state_reg <= ST_RUN;
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_reg))
        else $error("result lost under stall");
    a_noover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !cmd.step) else $error("overwrite");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && stat.emit |=> out_valid) else $error("result dropped");
endmodule

[design/lz77_triplet_compressor_unit.sv]
// Top level: LZ77 triplet compressor.
// Usage:
//  - in channel carries {in_byte, in_last}; out channel carries
//    {match_offset, match_length, literal_byte, final_triplet}.
//  - One byte is taken per cycle; all offsets are compared at once by
//    a row of comparator cells, so throughput is one item a cycle
//    while the receiver keeps up.
//  - A triplet appears on the output in the cycle after the byte that
//    closes it is taken, held in a single output register.
//  - When the receiver stalls with a triplet waiting, input is held off
//    until that triplet is taken; a byte is taken in the same cycle the
//    waiting triplet leaves.
//  - in_last closes the stream: the pending triplet goes out flagged
//    final and the window, candidates and counters return to reset.
//  - Reset (rst_n low) empties the window and the output register.
//  - No memory clearing pass is needed: an empty window is a fill count.
module lz77_triplet_compressor_unit #(
    parameter int WINDOW_SIZE = 255,
    parameter int MAX_MATCH   = 255
) (
    input  logic          clk,
    input  logic          rst_n,
    lz77_stream_if.sink   in_ch,
    lz77_stream_if.source out_ch
);
    lz77_pkg::lz77_cmd_t  cmd;
    lz77_pkg::lz77_stat_t stat;
    lz77_pkg::in_item_t   in_item;
    lz77_pkg::out_item_t  out_item;
    logic                 rdy;

    assign in_item     = in_ch.data;
    assign out_ch.data = out_item;
    // Input waits while a triplet sits unclaimed in the output register.
    assign in_ch.ready = rdy;

    lz77_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(rdy), .in_last(in_item.in_last),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_item(out_item), .cmd(cmd), .stat(stat)
    );

    lz77_datapath #(.WINDOW_SIZE(WINDOW_SIZE), .MAX_MATCH(MAX_MATCH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_byte(in_item.in_byte), .in_last(in_item.in_last), .stat(stat)
    );
endmodule

[tb/lz77_triplet_compressor_unit_test.sv]
// Testbench for the LZ77 triplet compressor: directed and random streams against a model.
`timescale 1ns / 100ps

module lz77_triplet_compressor_unit_test;

    localparam int WIN = 255;
    localparam int MAXM = 255;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    lz77_stream_if #(.W($bits(lz77_pkg::in_item_t)))  in_ch ();
    lz77_stream_if #(.W($bits(lz77_pkg::out_item_t))) out_ch ();

    lz77_triplet_compressor_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Model state: index 0 of the history is the newest byte.
    logic [7:0] hist [WIN];
    bit         alive [WIN];
    int         run_len;
    int         fill;
    bit         matching;

    lz77_pkg::out_item_t triplets_due [$];

    int  mismatches = 0;
    int  errors = 0;
    int  triplets_seen = 0;
    int  bytes_sent = 0;
    int  idle_cycles = 0;
    bit  src_calm = 0;     // no idling on the sender side
    bit  snk_calm = 0;     // no idling on the receiver side
    bit  snk_hold = 0;     // long receiver hold-off

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic model_clear();
        for (int d = 0; d < WIN; d++)
        begin
            hist[d] = 8'h00;
            alive[d] = 1'b0;
        end
        run_len = 0;
        fill = 0;
        matching = 1'b0;
    endtask

    // Greedy LZ77 step: queues at most one expected triplet.
    task automatic compress_byte(input logic [7:0] b, input logic last);
        bit        base [WIN];
        bit        surv [WIN];
        bit        any;
        int        off;
        lz77_pkg::out_item_t t;
        any = 1'b0;
        for (int d = 0; d < WIN; d++)
        begin
            base[d] = matching ? alive[d] : (d < fill);
            surv[d] = (run_len < MAXM) && base[d] && (hist[d] == b);
            if (surv[d])
                any = 1'b1;
        end
        if (any)
        begin
            run_len++;
            matching = 1'b1;
            alive = surv;
            if (last)
            begin
                off = 0;
                for (int d = WIN; d >= 1; d--)
                    if (off == 0 && surv[d-1])
                        off = d;
                t.match_offset = off[7:0];
                t.match_length = run_len[7:0];
                t.literal_byte = 8'h00;
                t.final_triplet = 1'b1;
                triplets_due.insert(triplets_due.size(), t);
            end
        end
        else
        begin
            off = 0;
            if (run_len != 0)
                for (int d = WIN; d >= 1; d--)
                    if (off == 0 && base[d-1])
                        off = d;
            t.match_offset = off[7:0];
            t.match_length = run_len[7:0];
            t.literal_byte = b;
            t.final_triplet = last;
            triplets_due.insert(triplets_due.size(), t);
            run_len = 0;
            matching = 1'b0;
            for (int d = 0; d < WIN; d++)
                alive[d] = 1'b0;
        end
        for (int d = WIN - 1; d > 0; d--)
            hist[d] = hist[d-1];
        hist[0] = b;
        if (fill < WIN)
            fill++;
        if (last)
            model_clear();
    endtask

    // Offer one byte with random gaps; the model steps when it is taken.
    // valid stays high after a take so back-to-back items need no gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        lz77_pkg::in_item_t it;
        while (!src_calm && $urandom_range(99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        it.in_byte = b;
        it.in_last = last;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        compress_byte(b, last);
        bytes_sent++;
    endtask

    task automatic stop_input();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random ready, with calm and hold-off stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (snk_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= snk_calm ? 1'b1 : ($urandom_range(99) >= 26);
    end

    // Checker: each taken triplet against the oldest expectation.
    always @(posedge clk)
    begin
        lz77_pkg::out_item_t got;
        lz77_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            triplets_seen++;
            if (triplets_due.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected triplet off=%0d len=%0d lit=%0d fin=%0d",
                             got.match_offset, got.match_length,
                             got.literal_byte, got.final_triplet);
            end
            else
            begin
                want = triplets_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                    begin
                        $display("triplet mismatch: exp off=%0d len=%0d lit=%0d fin=%0d",
                                 want.match_offset, want.match_length,
                                 want.literal_byte, want.final_triplet);
                        $display("                  got off=%0d len=%0d lit=%0d fin=%0d",
                                 got.match_offset, got.match_length,
                                 got.literal_byte, got.final_triplet);
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any item moving.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Literal corners: extremes of the byte, short streams, empty window.
    task automatic test_literals();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Overlapping match, tie to larger offset, end inside a match.
    task automatic test_matches();
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    // Run of one byte long enough to hit the match cap and fill the window;
    // both sides run without idling here.
    task automatic test_max_match();
        src_calm = 1'b1;
        snk_calm = 1'b1;
        for (int i = 0; i < 600; i++)
            send_byte(8'h77, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h77, 1'b1);
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    // Random streams: mostly repeats of recent bytes; new bytes come from a small alphabet or are random.
    task automatic test_random_streams();
        logic [7:0] recent [$];
        logic [7:0] b;
        int len;
        for (int s = 0; s < 20; s++)
        begin
            len = $urandom_range(60, 1);
            recent.delete();
            src_calm = (s % 6 == 3);
            snk_calm = (s % 6 == 3);
            for (int i = 0; i < len; i++)
            begin
                if (recent.size() > 0 && $urandom_range(99) < 60)
                    b = recent[$urandom_range(recent.size() - 1)];
                else if ($urandom_range(1))
                    b = 8'($urandom_range(3));
                else
                    b = 8'($urandom);
                recent.insert(recent.size(), b);
                send_byte(b, i == len - 1);
            end
        end
        src_calm = 0;
        snk_calm = 0;
    endtask

    // Receiver stops for a long stretch while bytes keep coming.
    task automatic test_backpressure();
        fork
            begin
                snk_hold = 1'b1;
                repeat (300) @(posedge clk);
                snk_hold = 1'b0;
            end
            begin
                for (int i = 0; i < 100; i++)
                    send_byte(8'($urandom_range(7)), i == 99);
            end
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        clk = 1'b0;
        model_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literals();
        test_matches();
        test_max_match();
        test_backpressure();
        test_random_streams();
        stop_input();

        while (triplets_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes, checked %0d triplets (literals, overlaps, cap, stalls).",
                 bytes_sent, triplets_seen);
        if (errors == 0 && triplets_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
